// ===== sv/isdb_pkg.sv =====
// shared types, operation codes and defaults for the double buffered readout engine
package isdb_pkg;

  localparam int FRAME_A_BYTES_DEF = 32;
  localparam int FRAME_B_BYTES_DEF = 32;

  localparam logic [2:0] OP_OFFSET  = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_LOAD_A  = 3'd2;
  localparam logic [2:0] OP_LOAD_B  = 3'd3;
  localparam logic [2:0] OP_PUBLISH = 3'd4;

  typedef logic [7:0] idx_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       readout_complete;
    logic       swapped_a;
    logic       swapped_b;
  } out_item_t;

  // read request toward one frame buffer
  typedef struct packed {
    logic half;
    idx_t idx;
  } frm_rd_t;

  // write request toward one frame buffer
  typedef struct packed {
    logic       en;
    logic       half;
    idx_t       idx;
    logic [7:0] data;
  } frm_wr_t;

endpackage

// ===== sv/i2c_slave_double_buffered_readout_top.sv =====
// top level of the ping-pong buffered readout engine
// an accepted command is captured into item_r and the execute state, and its result is registered onto out_valid
// one command at a time, taken only when idle; busy covers the single execute cycle that
//   consumes the registered read of the frame rams
// reset: synchronous active low; indexes, published halves and readout flag clear, done flags
//   set, frame bytes read as zero until loaded through per-entry valid bits (no clearing pass)
module i2c_slave_double_buffered_readout_top #(
  parameter int FRAME_A_BYTES = isdb_pkg::FRAME_A_BYTES_DEF,
  parameter int FRAME_B_BYTES = isdb_pkg::FRAME_B_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  isdb_pkg::in_item_t  in_item,
  output logic               out_valid,
  output isdb_pkg::out_item_t out_result
);

  // results are strobed for one cycle and the receiver cannot stall them

  localparam isdb_pkg::idx_t FA_SIZE = 8'(FRAME_A_BYTES);
  localparam isdb_pkg::idx_t FB_SIZE = 8'(FRAME_B_BYTES);
  localparam isdb_pkg::idx_t FA_LAST = 8'(FRAME_A_BYTES - 1);
  localparam isdb_pkg::idx_t FB_LAST = 8'(FRAME_B_BYTES - 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  isdb_pkg::in_item_t  item_r;

  // engine state
  isdb_pkg::idx_t      index_a_r, index_a_nxt;
  isdb_pkg::idx_t      index_b_r, index_b_nxt;
  logic                pub_a_r, pub_a_nxt;
  logic                pub_b_r, pub_b_nxt;
  logic                done_a_r, done_a_nxt;
  logic                done_b_r, done_b_nxt;
  logic                rflag_r, rflag_nxt;

  isdb_pkg::out_item_t out_result_r, out_result_nxt;
  logic                out_valid_r, out_valid_nxt;

  isdb_pkg::frm_rd_t   rd_a, rd_b;
  isdb_pkg::frm_wr_t   wr_a, wr_b;
  logic [7:0]          data_a, data_b;

  logic                accept;
  isdb_pkg::idx_t      pos_ext;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r == S_EXEC);
  assign pos_ext = {3'b000, item_r.byte_index};

  // the read cursor of each frame is presented every cycle; state only moves
  // at the end of execute, so the data seen in execute matches the accepted command
  assign rd_a = '{half: pub_a_r, idx: index_a_r};
  assign rd_b = '{half: pub_b_r, idx: index_b_r};

  always_comb begin
    state_nxt      = state_r;
    index_a_nxt    = index_a_r;
    index_b_nxt    = index_b_r;
    pub_a_nxt      = pub_a_r;
    pub_b_nxt      = pub_b_r;
    done_a_nxt     = done_a_r;
    done_b_nxt     = done_b_r;
    rflag_nxt      = rflag_r;
    out_result_nxt = '0;
    out_valid_nxt  = 1'b0;
    wr_a           = '{en: 1'b0, half: ~pub_a_r, idx: pos_ext, data: item_r.byte_value};
    wr_b           = '{en: 1'b0, half: ~pub_b_r, idx: pos_ext, data: item_r.byte_value};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (item_r.operation)
          isdb_pkg::OP_OFFSET: begin
            index_a_nxt = item_r.byte_value;
            index_b_nxt = (item_r.byte_value > FA_SIZE) ? item_r.byte_value - FA_SIZE
                                                        : 8'd0;
            done_a_nxt  = 1'b0;
            done_b_nxt  = 1'b0;
          end
          isdb_pkg::OP_READ: begin
            // frame a first, then frame b, zero once b is exhausted
            if (index_a_r < FA_SIZE) begin
              out_result_nxt.read_data = data_a;
              index_a_nxt              = index_a_r + 8'd1;
            end else if (index_b_r < FB_SIZE) begin
              out_result_nxt.read_data = data_b;
              index_b_nxt              = index_b_r + 8'd1;
            end
            if (index_a_nxt >= FA_LAST) begin
              done_a_nxt = 1'b1;
            end
            if (index_b_nxt >= FB_LAST) begin
              done_b_nxt = 1'b1;
              rflag_nxt  = 1'b1;
            end
          end
          isdb_pkg::OP_LOAD_A: begin
            // loads go to the hidden half, out of frame positions dropped
            wr_a.en = (pos_ext < FA_SIZE);
          end
          isdb_pkg::OP_LOAD_B: begin
            wr_b.en = (pos_ext < FB_SIZE);
          end
          isdb_pkg::OP_PUBLISH: begin
            out_result_nxt.readout_complete = rflag_r;
            out_result_nxt.swapped_a        = done_a_r;
            out_result_nxt.swapped_b        = done_b_r;
            rflag_nxt = 1'b0;
            pub_a_nxt = pub_a_r ^ done_a_r;
            pub_b_nxt = pub_b_r ^ done_b_r;
          end
          default: begin
            // unused codes leave state alone and return zeros
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      index_a_r   <= 8'd0;
      index_b_r   <= 8'd0;
      pub_a_r     <= 1'b0;
      pub_b_r     <= 1'b0;
      done_a_r    <= 1'b1;
      done_b_r    <= 1'b1;
      rflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      index_a_r   <= index_a_nxt;
      index_b_r   <= index_b_nxt;
      pub_a_r     <= pub_a_nxt;
      pub_b_r     <= pub_b_nxt;
      done_a_r    <= done_a_nxt;
      done_b_r    <= done_b_nxt;
      rflag_r     <= rflag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  isdb_frame #(
    .BYTES (FRAME_A_BYTES)
  ) u_frame_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_a),
    .wr_req  (wr_a),
    .rd_data (data_a)
  );

  isdb_frame #(
    .BYTES (FRAME_B_BYTES)
  ) u_frame_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_b),
    .wr_req  (wr_b),
    .rd_data (data_b)
  );

`ifndef ASSERT_OFF
  // an accepted command always gets its execute cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted command did not enter execute");

  // execute lasts exactly one cycle
  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("execute held longer than one cycle");

  // every result transfer follows an execute cycle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without execute");

  // a publish result never carries read data
  a_publish_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result.swapped_a || out_result.swapped_b
                  || out_result.readout_complete) |-> out_result.read_data == 8'd0)
    else $error("publish result carries read data");

  // the frame a cursor never runs past the frame through bus reads
  a_index_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy && (item_r.operation == isdb_pkg::OP_READ) && (index_a_r < FA_SIZE)
    |=> index_a_r <= FA_SIZE)
    else $error("frame a cursor overran");
`endif

endmodule

// ===== sv/isdb_ram.sv =====
// generic single write port ram with registered read
module isdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/isdb_frame.sv =====
// one ping-pong frame buffer: two halves in one ram, per-entry valid bits read as zero
module isdb_frame #(
  parameter int BYTES = isdb_pkg::FRAME_A_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  isdb_pkg::frm_rd_t rd_req,
  input  isdb_pkg::frm_wr_t wr_req,
  output logic [7:0]       rd_data
);

  localparam int DEPTH = 2 * BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(BYTES);

  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [7:0]       ram_q;
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic             rd_vld_r;

  // half 1 sits above half 0
  assign raddr = rd_req.half ? AW'(BYTES) + AW'(rd_req.idx[IW-1:0])
                             : AW'(rd_req.idx[IW-1:0]);
  assign waddr = wr_req.half ? AW'(BYTES) + AW'(wr_req.idx[IW-1:0])
                             : AW'(wr_req.idx[IW-1:0]);

  always_comb begin
    valid_nxt = valid_r;
    if (wr_req.en) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rd_vld_r <= valid_r[raddr];
    end
  end

  isdb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_req.en),
    .waddr (waddr),
    .wdata (wr_req.data),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // never written entries read as zero
  assign rd_data = rd_vld_r ? ram_q : 8'd0;

endmodule
